>>> design/csr_sparse_matrix_vector_multiply_top_macros.svh
// Assertion macros for the sparse matrix-vector multiply block.
`ifndef CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_TOP_MACROS_SVH
`define CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_TOP_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define CSRSPMV_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csrspmv: same-cycle check failed");
// Next-cycle implication, checked out of reset.
`define CSRSPMV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csrspmv: next-cycle check failed");
`else
`define CSRSPMV_ASSERT_NOW(lbl, ante, cons)
`define CSRSPMV_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> design/csrspmv_pkg.sv
// Constants shared by the sparse matrix-vector multiply block.
`default_nettype none
package csrspmv_pkg;
    localparam int MAX_SIZE = 1024;
    localparam int ADDR_W   = $clog2(MAX_SIZE);
    localparam int SIZE_W   = 11;
    localparam int IDX_W    = 10;
    localparam int VAL_W    = 32;
    localparam int SUM_W    = 64;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_NZ   = 2'd1;
    localparam logic [1:0] CMD_EOR  = 2'd2;
endpackage
`default_nettype wire

>>> design/csr_sparse_matrix_vector_multiply_top.sv
// Top level of the CSR sparse matrix-vector multiply block.
//
// Usage:
//   Input channel (in_valid / in_stall) carries commands: load a vector
//   element (cmd, index, operand_value), a matrix nonzero (column in index,
//   value in operand_value), or end of row. Output channel (out_valid /
//   out_stall) carries one transfer per end of row: row_number, row_sum
//   (saturated Q32.32), column_error and overflow.
//   Configuration: cfg_we / cfg_data write active_size while idle.
//   Throughput: one command per cycle while in_stall is low. Loads write
//   the vector RAM at the accept edge; a nonzero reads the RAM at its accept
//   edge, its product is registered in stage 2, then added into the accumulator.
//   Result path: an end-of-row command passes stage 1, stage 2 and the output
//   registers before its result shows on the output ports.
//   Reset: accumulator, row counter, flags and pipeline valids clear;
//   active_size returns to 1024. The vector RAM is not cleared, so every
//   element must be loaded before a nonzero uses it.
//   Stall: while a result sits on the output and out_stall is high, the
//   whole pipeline holds and in_stall is raised; nothing is dropped.
`default_nettype none
`include "csr_sparse_matrix_vector_multiply_top_macros.svh"
module csr_sparse_matrix_vector_multiply_top
    import csrspmv_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [1:0]               cmd,
    input  wire logic [IDX_W-1:0]         index,
    input  wire logic signed [VAL_W-1:0]  operand_value,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [IDX_W-1:0]              row_number,
    output logic signed [SUM_W-1:0]       row_sum,
    output logic                          column_error,
    output logic                          overflow,
    input  wire logic                     cfg_we,
    input  wire logic [SIZE_W-1:0]        cfg_data
);

    typedef enum logic {KIND_NZ, KIND_EOR} kind_t;

    // vector store: one write and one read port, registered read
    logic [VAL_W-1:0] vec_mem [MAX_SIZE];
    logic signed [VAL_W-1:0] mem_rd_reg;

    logic [SIZE_W-1:0] active_size_reg;
    logic [SIZE_W-1:0] eff_size;
    logic              advance;
    logic              accept;
    logic              col_in_range;
    logic [ADDR_W-1:0] addr;

    // stage 1: operand waiting for RAM data
    logic                     s1_valid_reg;
    kind_t                    s1_kind_reg;
    logic                     s1_bad_reg;
    logic signed [VAL_W-1:0]  s1_operand_reg;

    // stage 2: product waiting for accumulate
    logic                     s2_valid_reg;
    kind_t                    s2_kind_reg;
    logic                     s2_bad_reg;
    logic signed [SUM_W-1:0]  s2_product_reg;
    logic signed [SUM_W-1:0]  product;

    // row state
    logic signed [SUM_W-1:0]  acc_reg;
    logic signed [SUM_W-1:0]  acc_next;
    logic                     colerr_reg;
    logic                     ovf_reg;
    logic                     ovf_next;
    logic [IDX_W-1:0]         row_cnt_reg;
    logic [IDX_W-1:0]         row_cnt_next;
    logic [SUM_W:0]           sum_wide;

    logic                     out_valid_reg;
    logic [IDX_W-1:0]         row_number_reg;
    logic signed [SUM_W-1:0]  row_sum_reg;
    logic                     column_error_reg;
    logic                     overflow_reg;

    // zero counts as one, anything past the RAM depth as the depth
    always_comb
    begin
        eff_size = active_size_reg;
        if (active_size_reg == '0)
        begin
            eff_size = SIZE_W'(1);
        end
        else if (32'(active_size_reg) > MAX_SIZE)
        begin
            eff_size = SIZE_W'(MAX_SIZE);
        end
    end

    // a parked result blocks the whole pipe
    assign advance      = !(out_valid_reg && out_stall);
    assign in_stall     = !advance;
    assign accept       = in_valid && advance;
    assign col_in_range = (SIZE_W'(index) < eff_size);
    assign addr         = ADDR_W'(index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_size_reg <= SIZE_W'(1024);
        end
        else if (cfg_we)
        begin
            active_size_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && cmd == CMD_LOAD && col_in_range)
        begin
            vec_mem[addr] <= operand_value;
        end
        if (accept)
        begin
            mem_rd_reg <= vec_mem[addr];
        end
    end

    assign product = s1_operand_reg * mem_rd_reg;

    // saturating accumulate
    always_comb
    begin
        sum_wide = {acc_reg[SUM_W-1], acc_reg} + {s2_product_reg[SUM_W-1], s2_product_reg};
        acc_next = sum_wide[SUM_W-1:0];
        ovf_next = ovf_reg;
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            ovf_next = 1'b1;
            acc_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                       : {1'b0, {(SUM_W-1){1'b1}}};
        end
    end

    assign row_cnt_next = ((SIZE_W'(row_cnt_reg) + SIZE_W'(1)) >= eff_size)
                          ? '0 : row_cnt_reg + IDX_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            colerr_reg    <= 1'b0;
            ovf_reg       <= 1'b0;
            row_cnt_reg   <= '0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= accept && (cmd == CMD_NZ || cmd == CMD_EOR);
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg && s2_kind_reg == KIND_EOR;
            if (s2_valid_reg)
            begin
                case (s2_kind_reg)
                    KIND_NZ:
                    begin
                        if (s2_bad_reg)
                        begin
                            colerr_reg <= 1'b1;
                        end
                        else
                        begin
                            acc_reg <= acc_next;
                            ovf_reg <= ovf_next;
                        end
                    end
                    KIND_EOR:
                    begin
                        acc_reg     <= '0;
                        colerr_reg  <= 1'b0;
                        ovf_reg     <= 1'b0;
                        row_cnt_reg <= row_cnt_next;
                    end
                    default:
                    begin
                        acc_reg <= acc_reg;
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (accept)
            begin
                s1_kind_reg    <= (cmd == CMD_EOR) ? KIND_EOR : KIND_NZ;
                s1_bad_reg     <= !col_in_range;
                s1_operand_reg <= operand_value;
            end
            s2_kind_reg    <= s1_kind_reg;
            s2_bad_reg     <= s1_bad_reg;
            s2_product_reg <= product;
            if (s2_valid_reg && s2_kind_reg == KIND_EOR)
            begin
                row_number_reg   <= row_cnt_reg;
                row_sum_reg      <= acc_reg;
                column_error_reg <= colerr_reg;
                overflow_reg     <= ovf_reg;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign row_number   = row_number_reg;
    assign row_sum      = row_sum_reg;
    assign column_error = column_error_reg;
    assign overflow     = overflow_reg;

    `CSRSPMV_ASSERT_NEXT(a_eor_emits, advance && s2_valid_reg && s2_kind_reg == KIND_EOR,
        out_valid_reg && row_number_reg == $past(row_cnt_reg))
    `CSRSPMV_ASSERT_NEXT(a_nz_enters, accept && cmd == CMD_NZ, s1_valid_reg && s1_kind_reg == KIND_NZ)
    `CSRSPMV_ASSERT_NEXT(a_stall_holds, !advance,
        $stable(acc_reg) && $stable(row_cnt_reg) && $stable(s2_valid_reg))

endmodule
`default_nettype wire

>>> verif/csr_sparse_matrix_vector_multiply_checker.sv
`timescale 1ns / 1ps
// Row-result predictor and scoreboard for the CSR sparse matrix-vector multiply block.
module csr_sparse_matrix_vector_multiply_checker
    import csrspmv_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic [1:0]              cmd,
    input  logic [IDX_W-1:0]        index,
    input  logic signed [VAL_W-1:0] operand_value,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic [IDX_W-1:0]        row_number,
    input  logic signed [SUM_W-1:0] row_sum,
    input  logic                    column_error,
    input  logic                    overflow,
    input  logic                    cfg_we,
    input  logic [SIZE_W-1:0]       cfg_data,
    output int                      failures,
    output int                      pending
);
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic [IDX_W-1:0]        row;
        logic signed [SUM_W-1:0] sum;
        logic                    col_err;
        logic                    ovf;
    } row_result_t;

    row_result_t             expected_rows[$];
    logic signed [VAL_W-1:0] vec_mem [MAX_SIZE];
    logic signed [SUM_W-1:0] row_acc;
    logic [IDX_W-1:0]        row_idx;
    logic                    col_err_seen;
    logic                    sat_seen;
    logic [SIZE_W-1:0]       size_reg;
    int                      errors;

    assign failures = errors;

    always @(posedge clk or negedge rst_n)
    begin
        int          n;
        longint      lhs;
        longint      rhs;
        longint      prod;
        logic [SUM_W:0] wide;
        row_result_t exp_row;

        if (!rst_n)
        begin
            expected_rows.delete();
            row_acc      = '0;
            row_idx      = '0;
            col_err_seen = 1'b0;
            sat_seen     = 1'b0;
            size_reg     = SIZE_W'(MAX_SIZE);
            errors       = 0;
            pending     <= 0;
        end
        else
        begin
            // result side first: an end of row never completes in the cycle it is accepted
            if (out_valid && !out_stall)
            begin
                if (expected_rows.size() == 0)
                begin
                    $error("unexpected row result: row_number %0d", row_number);
                    errors++;
                end
                else
                begin
                    exp_row = expected_rows.pop_front();
                    if (row_number !== exp_row.row)
                    begin
                        $error("row_number: expected %0d, got %0d", exp_row.row, row_number);
                        errors++;
                    end
                    if (row_sum !== exp_row.sum)
                    begin
                        $error("row_sum: expected %0d, got %0d",
                               $signed(exp_row.sum), row_sum);
                        errors++;
                    end
                    if (column_error !== exp_row.col_err)
                    begin
                        $error("column_error: expected %0b, got %0b",
                               exp_row.col_err, column_error);
                        errors++;
                    end
                    if (overflow !== exp_row.ovf)
                    begin
                        $error("overflow: expected %0b, got %0b", exp_row.ovf, overflow);
                        errors++;
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                n = (size_reg == 0) ? 1 : (size_reg > MAX_SIZE) ? MAX_SIZE : int'(size_reg);
                case (cmd)
                    CMD_LOAD:
                    begin
                        if (index < n)
                            vec_mem[index] = operand_value;
                    end
                    CMD_NZ:
                    begin
                        if (index >= n)
                            col_err_seen = 1'b1;
                        else
                        begin
                            lhs  = operand_value;
                            rhs  = vec_mem[index];
                            prod = lhs * rhs;
                            wide = {row_acc[SUM_W-1], row_acc} + {prod[SUM_W-1], prod};
                            if (wide[SUM_W] != wide[SUM_W-1])
                            begin
                                sat_seen = 1'b1;
                                row_acc  = wide[SUM_W] ? SUM_MIN : SUM_MAX;
                            end
                            else
                                row_acc = wide[SUM_W-1:0];
                        end
                    end
                    CMD_EOR:
                    begin
                        exp_row.row     = row_idx;
                        exp_row.sum     = row_acc;
                        exp_row.col_err = col_err_seen;
                        exp_row.ovf     = sat_seen;
                        expected_rows.insert(expected_rows.size(), exp_row);
                        row_acc      = '0;
                        col_err_seen = 1'b0;
                        sat_seen     = 1'b0;
                        row_idx      = (int'(row_idx) + 1 >= n) ? '0 : row_idx + 1'b1;
                    end
                    default: ;
                endcase
            end

            if (cfg_we)
                size_reg = cfg_data;

            pending <= expected_rows.size();
        end
    end
endmodule

>>> verif/tb_csr_sparse_matrix_vector_multiply_top.sv
`timescale 1ns / 1ps
// Testbench top: command stimulus, handshake idling, watchdog and verdict for the SpMV block.
module tb_csr_sparse_matrix_vector_multiply_top;
    import csrspmv_pkg::*;

    // cmd code 3 is not in the package; the block must ignore it
    localparam logic [1:0] CMD_NOP = 2'd3;

    localparam int WAIT_MAX     = 16;    // longest idle draw on either side
    localparam int QUIET_LIMIT  = 4000;  // cycles with no transfer before we give up
    localparam int DRAIN_CYCLES = 8;     // covers the two-stage MAC pipeline with margin
    localparam int PHASE_ITEMS  = 103;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [1:0]              cmd;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] operand_value;
    logic                    out_valid;
    logic                    out_stall;
    logic [IDX_W-1:0]        row_number;
    logic signed [SUM_W-1:0] row_sum;
    logic                    column_error;
    logic                    overflow;
    logic                    cfg_we;
    logic [SIZE_W-1:0]       cfg_data;

    int failures;
    int pending;

    // Stimulus-side view of the block: which vector entries hold data and the
    // effective matrix size. A nonzero in range only ever reads an entry loaded earlier.
    bit vec_loaded [MAX_SIZE];
    int cur_size;
    int sent_items;

    // When set, that side runs back to back; toggled now and then so that
    // long gap-free stretches alternate with heavy idling.
    bit sender_calm;
    bit receiver_calm;

    int quiet_cycles;

    csr_sparse_matrix_vector_multiply_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .index         (index),
        .operand_value (operand_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .row_number    (row_number),
        .row_sum       (row_sum),
        .column_error  (column_error),
        .overflow      (overflow),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data)
    );

    csr_sparse_matrix_vector_multiply_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .index         (index),
        .operand_value (operand_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .row_number    (row_number),
        .row_sum       (row_sum),
        .column_error  (column_error),
        .overflow      (overflow),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .failures      (failures),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int draw_wait(input bit calm);
        return calm ? 0 : int'($urandom_range(0, WAIT_MAX));
    endfunction

    // Q16.16 operand mix: both extremes, zero, -1 LSB, small magnitudes, and
    // full-range noise. The extremes make saturation reachable in a few terms.
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return '1;
            4, 5, 6: return VAL_W'($urandom_range(0, 2**21) - 2**20);
            default: return $urandom();
        endcase
    endfunction

    // One input transfer. Valid is lowered only for a drawn gap, so back-to-back
    // items keep it high; the payload holds until the accepting edge.
    task automatic send_item(input logic [1:0] op, input int idx, input logic [VAL_W-1:0] val);
        int gap;
        gap = draw_wait(sender_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        cmd           <= op;
        index         <= IDX_W'(idx);
        operand_value <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (op == CMD_LOAD && idx < cur_size)
            vec_loaded[idx] = 1'b1;
        // ignored commands and out-of-range loads do not count as work
        if (op == CMD_NZ || op == CMD_EOR || (op == CMD_LOAD && idx < cur_size))
            sent_items++;
    endtask

    // A nonzero in range needs its vector element; load one first if missing.
    task automatic send_nonzero(input int col, input logic [VAL_W-1:0] val);
        if (col < cur_size && !vec_loaded[col])
            send_item(CMD_LOAD, col, pick_value());
        send_item(CMD_NZ, col, val);
    endtask

    // Size change only with the block idle: every row result back, then the
    // pipeline drain, since trailing loads and nonzeros give no result.
    task automatic write_size(input logic [SIZE_W-1:0] sz);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= sz;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_size = (sz == 0) ? 1 : (sz > MAX_SIZE) ? MAX_SIZE : int'(sz);
    endtask

    // Mostly well-formed rows (nonzeros then end of row) with random content;
    // roughly one pick in ten is noise: ignored commands, stray loads, stray ends of row, bad columns.
    task automatic run_phase(input logic [SIZE_W-1:0] sz);
        int start;
        int terms;
        int col;
        int op;
        write_size(sz);
        start = sent_items;
        repeat (4) send_item(CMD_LOAD, $urandom_range(0, cur_size - 1), pick_value());
        while (sent_items - start < PHASE_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                op = $urandom_range(0, 3);
                if (op == CMD_NZ)
                    send_nonzero($urandom_range(0, MAX_SIZE - 1), pick_value());
                else
                    send_item(2'(op), $urandom_range(0, MAX_SIZE - 1), pick_value());
            end
            else
            begin
                terms = $urandom_range(0, 6);
                repeat (terms)
                begin
                    // occasional column drawn over the whole RAM; one past the active size raises the row's error flag
                    if ($urandom_range(0, 9) == 0)
                        col = $urandom_range(0, MAX_SIZE - 1);
                    else
                        col = $urandom_range(0, cur_size - 1);
                    if ($urandom_range(0, 7) == 0)
                        send_item(CMD_LOAD, $urandom_range(0, cur_size - 1), pick_value());
                    send_nonzero(col, pick_value());
                end
                send_item(CMD_EOR, $urandom_range(0, MAX_SIZE - 1), $urandom());
            end
            if ($urandom_range(0, 7) == 0)
                sender_calm = !sender_calm;
        end
    endtask

    // Result side: draw a stall per result, then take the next transfer.
    initial
    begin
        int hold;
        out_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            hold = draw_wait(receiver_calm);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            if ($urandom_range(0, 15) == 0)
                receiver_calm = !receiver_calm;
        end
    end

    // Watchdog: any stretch with no transfer on either channel this long means a hang.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        cmd           <= CMD_LOAD;
        index         <= '0;
        operand_value <= '0;
        cfg_we        <= 1'b0;
        cfg_data      <= '0;
        cur_size      = MAX_SIZE;
        sent_items    = 0;
        sender_calm   = 1'b0;
        receiver_calm = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset size (1024).
        // Positive saturation: (-1.0 * 2^15)^2 twice reaches 2^63, then a further
        // term keeps adding to the clamped value.
        send_item(CMD_LOAD, 0, 32'h8000_0000);
        send_item(CMD_LOAD, MAX_SIZE - 1, 32'h7FFF_FFFF);
        send_item(CMD_LOAD, 1, 32'h0001_0000);
        send_nonzero(0, 32'h8000_0000);
        send_nonzero(0, 32'h8000_0000);
        send_nonzero(1, 32'h7FFF_FFFF);
        send_item(CMD_EOR, 0, '0);
        // Negative saturation: three products near -2^62.
        repeat (3) send_nonzero(MAX_SIZE - 1, 32'h8000_0000);
        send_item(CMD_EOR, MAX_SIZE - 1, '1);
        // Empty row gives zero.
        send_item(CMD_EOR, 0, '0);
        // Reserved command is dropped with no state change.
        send_item(CMD_NOP, MAX_SIZE - 1, 32'h7FFF_FFFF);
        send_nonzero(1, 32'hFFFF_FFFF);
        send_item(CMD_EOR, 0, '0);

        // Size 2: load past the end is dropped, a column past the end flags
        // the row, and the row counter (at 4) wraps to zero on the next row.
        write_size(11'd2);
        send_item(CMD_LOAD, 5, 32'h1234_5678);
        send_nonzero(1, 32'h0002_0000);
        send_nonzero(2, 32'h7FFF_FFFF);
        send_item(CMD_EOR, 0, '0);
        repeat (3) send_item(CMD_EOR, 0, '0);

        // Random phases over the size extremes (0 acts as 1, 2047 as 1024) and
        // a spread of ordinary sizes. Each size write doubles as a full drain.
        run_phase(11'd2047);
        run_phase(11'd1);
        run_phase('0);
        run_phase(11'd1024);
        run_phase(11'd3);
        run_phase(SIZE_W'($urandom_range(2, 64)));
        run_phase(SIZE_W'($urandom_range(2, 64)));
        run_phase(SIZE_W'($urandom_range(1, 2047)));
        run_phase(SIZE_W'($urandom_range(1, 2047)));
        run_phase(11'd16);

        // Drain: all row results back, then the DRAIN_CYCLES wait for anything stray.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
